[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define PTS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("scheduler check failed");

// property checked on every rising edge, reset included
`define PTS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("scheduler reset check failed");

`endif

[rtl/pts_pkg.sv]
// package: types, codes and constants of the priority thread scheduler
package pts_pkg;

   localparam int NumPrioDef = 32;
   localparam int PrioW      = 6;
   localparam int TicksW     = 32;
   localparam int GrpW       = 8;
   localparam int PosW       = 3;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_DELAY = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_USED       = 2'd1;
   localparam logic [1:0] STAT_IDLE_DELAY = 2'd2;
   localparam logic [1:0] STAT_ZERO_DELAY = 2'd3;

   typedef struct packed {
      logic [1:0]        mode;
      logic [PrioW-1:0]  prio;
      logic [TicksW-1:0] ticks;
   } req_type;

   typedef struct packed {
      logic [PrioW-1:0] next_prio;
      logic             switch_needed;
      logic [1:0]       status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SWEEP,
      S_PICK_GRP,
      S_PICK_TOP
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic sweep;
      logic pick_grp;
      logic pick_top;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic sweep_done;
      logic out_busy;
   } sts_type;

endpackage

[rtl/pts_ctrl.sv]
// controller state machine of the priority thread scheduler
module pts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pts_pkg::sts_type sts,
   output pts_pkg::cmd_type cmd
);

   pts_pkg::state_type state_ff;
   pts_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pts_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pts_pkg::S_IDLE: begin
            if (req_valid) state_in = pts_pkg::S_EXEC;
         end
         pts_pkg::S_EXEC: begin
            state_in = sts.is_tick ? pts_pkg::S_SWEEP : pts_pkg::S_PICK_GRP;
         end
         pts_pkg::S_SWEEP: begin
            if (sts.sweep_done) state_in = pts_pkg::S_PICK_GRP;
         end
         pts_pkg::S_PICK_GRP: begin
            state_in = pts_pkg::S_PICK_TOP;
         end
         pts_pkg::S_PICK_TOP: begin
            if (!sts.out_busy) state_in = pts_pkg::S_IDLE;
         end
         default: begin
            state_in = pts_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         pts_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         pts_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
         end
         pts_pkg::S_SWEEP: begin
            cmd.sweep = 1'b1;
         end
         pts_pkg::S_PICK_GRP: begin
            cmd.pick_grp = 1'b1;
         end
         pts_pkg::S_PICK_TOP: begin
            cmd.pick_top = !sts.out_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

[rtl/pts_dp.sv]
// datapath: masks, timeout memory, tick sweep, priority pick and result register
module pts_dp #(
   parameter int NUM_PRIO = pts_pkg::NumPrioDef
) (
   input  logic             clock,
   input  logic             reset,
   input  pts_pkg::req_type req_data,
   input  pts_pkg::cmd_type cmd,
   output pts_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pts_pkg::rsp_type rsp_data
);

   localparam int IdxW = $clog2(NUM_PRIO);
   localparam int CntW = $clog2(NUM_PRIO + 1);
   localparam int SelW = $clog2(NUM_PRIO + 1);
   localparam int NGrp = (NUM_PRIO + pts_pkg::GrpW - 1) / pts_pkg::GrpW;

   pts_pkg::req_type req_ff;
   pts_pkg::req_type req_in;

   logic [NUM_PRIO-1:0]      ready_ff, ready_in;
   logic [NUM_PRIO-1:0]      delayed_ff, delayed_in;
   logic [NUM_PRIO:0]        started_ff, started_in;
   logic [pts_pkg::PrioW-1:0] cur_ff, cur_in;
   logic [1:0]               stat_ff, stat_in;

   logic [CntW-1:0]          idx_ff, idx_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic [IdxW-1:0]          rd_idx_ff;
   logic [pts_pkg::TicksW-1:0] rd_data_ff;
   logic [pts_pkg::TicksW-1:0] dec;

   logic [pts_pkg::TicksW-1:0] mem [NUM_PRIO];
   logic                     wr_en;
   logic [IdxW-1:0]          wr_addr;
   logic [pts_pkg::TicksW-1:0] wr_data;
   logic [IdxW-1:0]          rd_addr;

   logic [NGrp*pts_pkg::GrpW-1:0] rdy_pad;
   logic [NGrp-1:0]          grp_any_ff, grp_any_in;
   logic [pts_pkg::PosW-1:0] grp_pos_ff [NGrp];
   logic [pts_pkg::PosW-1:0] grp_pos_in [NGrp];
   logic [pts_pkg::PrioW-1:0] pick;

   logic                     rsp_valid_ff, rsp_valid_in;
   pts_pkg::rsp_type         rsp_ff, rsp_in;

   logic [pts_pkg::PrioW-1:0] p_m1;
   logic [pts_pkg::PrioW-1:0] cur_m1;
   logic                     p_ok;
   logic                     delay_ok;

   assign p_m1   = req_ff.prio - pts_pkg::PrioW'(1);
   assign cur_m1 = cur_ff - pts_pkg::PrioW'(1);
   assign p_ok   = (req_ff.prio <= pts_pkg::PrioW'(NUM_PRIO)) &&
                   !started_ff[req_ff.prio[SelW-1:0]];
   assign delay_ok = cmd.exec && (req_ff.mode == pts_pkg::MODE_DELAY) &&
                     (cur_ff != '0) && (cur_ff <= pts_pkg::PrioW'(NUM_PRIO)) &&
                     (req_ff.ticks != '0);

   assign dec = rd_data_ff - pts_pkg::TicksW'(1);

   // captured transaction, the start / delay update and the timeout expiry update
   always_comb begin
      req_in     = cmd.load ? req_data : req_ff;
      ready_in   = ready_ff;
      delayed_in = delayed_ff;
      started_in = started_ff;
      stat_in    = stat_ff;
      if (cmd.exec) begin
         stat_in = pts_pkg::STAT_OK;
         if (req_ff.mode == pts_pkg::MODE_START) begin
            if (!p_ok) begin
               stat_in = pts_pkg::STAT_USED;
            end else begin
               started_in[req_ff.prio[SelW-1:0]] = 1'b1;
               if (req_ff.prio != '0) ready_in[p_m1[IdxW-1:0]] = 1'b1;
            end
         end else if (req_ff.mode == pts_pkg::MODE_DELAY) begin
            if (cur_ff == '0 || cur_ff > pts_pkg::PrioW'(NUM_PRIO)) begin
               stat_in = pts_pkg::STAT_IDLE_DELAY;
            end else if (req_ff.ticks == '0) begin
               stat_in = pts_pkg::STAT_ZERO_DELAY;
            end else begin
               ready_in[cur_m1[IdxW-1:0]]   = 1'b0;
               delayed_in[cur_m1[IdxW-1:0]] = 1'b1;
            end
         end
      end
      if (rd_vld_ff && dec == '0) begin
         ready_in[rd_idx_ff]   = 1'b1;
         delayed_in[rd_idx_ff] = 1'b0;
      end
   end

   // tick sweep: read one entry a cycle, write back the decrement in the next cycle
   always_comb begin
      idx_in    = idx_ff;
      rd_vld_in = 1'b0;
      rd_addr   = idx_ff[IdxW-1:0];
      if (cmd.exec) begin
         idx_in = '0;
      end else if (cmd.sweep && idx_ff < CntW'(NUM_PRIO)) begin
         idx_in    = idx_ff + CntW'(1);
         rd_vld_in = delayed_ff[idx_ff[IdxW-1:0]];
      end
   end

   assign sts.sweep_done = (idx_ff == CntW'(NUM_PRIO));
   assign sts.is_tick    = (req_ff.mode == pts_pkg::MODE_TICK);
   assign sts.out_busy   = rsp_valid_ff && !rsp_ready;

   always_comb begin
      wr_en   = delay_ok || rd_vld_ff;
      wr_addr = delay_ok ? cur_m1[IdxW-1:0] : rd_idx_ff;
      wr_data = delay_ok ? req_ff.ticks : dec;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   // highest ready priority: per group of eight, then across groups
   always_comb begin
      rdy_pad               = '0;
      rdy_pad[NUM_PRIO-1:0] = ready_ff;
      for (int g = 0; g < NGrp; g++) begin
         grp_any_in[g] = 1'b0;
         grp_pos_in[g] = '0;
         for (int b = 0; b < pts_pkg::GrpW; b++) begin
            if (rdy_pad[g*pts_pkg::GrpW + b]) begin
               grp_any_in[g] = 1'b1;
               grp_pos_in[g] = pts_pkg::PosW'(b);
            end
         end
      end
   end

   always_comb begin
      pick = '0;
      for (int g = 0; g < NGrp; g++) begin
         if (grp_any_ff[g]) begin
            pick = pts_pkg::PrioW'(g * pts_pkg::GrpW) +
                   pts_pkg::PrioW'(grp_pos_ff[g]) + pts_pkg::PrioW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pick_grp) begin
         grp_any_ff <= grp_any_in;
         grp_pos_ff <= grp_pos_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cur_in       = cur_ff;
      if (cmd.pick_top) begin
         rsp_valid_in         = 1'b1;
         rsp_in.next_prio     = pick;
         rsp_in.switch_needed = (pick != cur_ff);
         rsp_in.status        = stat_ff;
         cur_in               = pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= '0;
         delayed_ff   <= '0;
         started_ff   <= '0;
         cur_ff       <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ready_ff     <= ready_in;
         delayed_ff   <= delayed_in;
         started_ff   <= started_in;
         cur_ff       <= cur_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      stat_ff <= stat_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/priority_thread_scheduler.sv]
// top level of the priority thread scheduler
// Preemptive priority scheduler for NUM_PRIO threads plus the idle thread at
// priority 0. One transaction is worked on at a time. A start, delay or
// unused-mode transaction passes through the execute, group-pick and top-pick
// steps before the next one can be accepted. A tick also runs the sweep after
// the execute step; the sweep reads one stored timeout per cycle and writes
// back its decrement in the next cycle, through the separate read and write
// ports of the timeout memory. The result waits in an output register, so a
// new transaction is accepted while the previous result is still not taken.
// The next result then waits in the final step until that one is taken.
// Every transaction yields exactly one result transaction.
module priority_thread_scheduler #(
   parameter int NUM_PRIO = pts_pkg::NumPrioDef
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pts_pkg::rsp_type rsp_data
);

   pts_pkg::cmd_type cmd;
   pts_pkg::sts_type sts;

   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pts_dp #(
      .NUM_PRIO (NUM_PRIO)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/pts_checker.sv]
// port checker of the priority thread scheduler and its bind
`include "assert_macros.svh"

module pts_checker #(
   parameter int NUM_PRIO = pts_pkg::NumPrioDef
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input pts_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pts_pkg::rsp_type rsp_data
);

   logic [pts_pkg::PrioW-1:0] last_prio_ff;
   logic [pts_pkg::PrioW-1:0] last_prio_in;
   logic                      req_seen;

   assign req_seen     = req_valid && req_ready && (req_data.mode != pts_pkg::MODE_TICK);
   assign last_prio_in = (rsp_valid && rsp_ready) ? rsp_data.next_prio : last_prio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_prio_ff <= '0;
      end else begin
         last_prio_ff <= last_prio_in;
      end
   end

   `PTS_ASSERT(a_prio_range, clock, reset, rsp_valid |-> (rsp_data.next_prio <= pts_pkg::PrioW'(NUM_PRIO)) || req_seen)
   `PTS_ASSERT(a_switch_flag, clock, reset, rsp_valid |-> (rsp_data.switch_needed == (rsp_data.next_prio != last_prio_ff)))
   `PTS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
   `PTS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind priority_thread_scheduler pts_checker #(
   .NUM_PRIO (NUM_PRIO)
) u_pts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[sim/tb.sv]
// testbench of the priority thread scheduler: directed and random transactions
module tb;

   localparam int NPRIO = pts_pkg::NumPrioDef;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int MAX_PRINTS = 100;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pts_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   pts_pkg::rsp_type rsp_data;

   // scheduler state as predicted
   logic [NPRIO-1:0]           sched_ready_mask = '0;
   logic [NPRIO-1:0]           sched_delayed_mask = '0;
   logic [NPRIO:0]             sched_started_mask = '0;
   logic [pts_pkg::TicksW-1:0] sched_countdown [NPRIO];
   logic [pts_pkg::PrioW-1:0]  sched_current = '0;

   pts_pkg::req_type sched_stim_q[$];
   pts_pkg::rsp_type sched_expected_q[$];

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned rsp_hold_left = 0;
   logic        rsp_hold_go = 1'b0;
   int unsigned sched_err_count = 0;

   priority_thread_scheduler #(.NUM_PRIO(NPRIO)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic pts_pkg::rsp_type sched_predict(pts_pkg::req_type r);
      pts_pkg::rsp_type          res;
      logic [1:0]                stat;
      logic [pts_pkg::PrioW-1:0] pick;
      stat = pts_pkg::STAT_OK;
      case (r.mode)
         pts_pkg::MODE_START: begin
            if (r.prio > NPRIO) begin
               stat = pts_pkg::STAT_USED;
            end else if (sched_started_mask[r.prio]) begin
               stat = pts_pkg::STAT_USED;
            end else begin
               sched_started_mask[r.prio] = 1'b1;
               if (r.prio != 0) sched_ready_mask[r.prio-1] = 1'b1;
            end
         end
         pts_pkg::MODE_DELAY: begin
            if (sched_current == 0) begin
               stat = pts_pkg::STAT_IDLE_DELAY;
            end else if (r.ticks == 0) begin
               stat = pts_pkg::STAT_ZERO_DELAY;
            end else begin
               sched_countdown[sched_current-1] = r.ticks;
               sched_ready_mask[sched_current-1] = 1'b0;
               sched_delayed_mask[sched_current-1] = 1'b1;
            end
         end
         pts_pkg::MODE_TICK: begin
            for (int i = 0; i < NPRIO; i++) begin
               if (sched_delayed_mask[i]) begin
                  sched_countdown[i] = sched_countdown[i] - 1;
                  if (sched_countdown[i] == 0) begin
                     sched_ready_mask[i] = 1'b1;
                     sched_delayed_mask[i] = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase
      pick = '0;
      for (int p = NPRIO; p >= 1; p--) begin
         if (pick == 0 && sched_ready_mask[p-1]) pick = pts_pkg::PrioW'(p);
      end
      res.next_prio = pick;
      res.switch_needed = (pick != sched_current);
      res.status = stat;
      sched_current = pick;
      return res;
   endfunction

   function automatic pts_pkg::req_type mk_req(logic [1:0] mode, int unsigned prio,
                                               logic [pts_pkg::TicksW-1:0] ticks);
      pts_pkg::req_type r;
      r.mode = mode;
      r.prio = pts_pkg::PrioW'(prio);
      r.ticks = ticks;
      return r;
   endfunction

   // mostly well-formed scheduling traffic with some noise
   function automatic pts_pkg::req_type mk_random_req();
      pts_pkg::req_type r;
      int unsigned      sel;
      sel = $urandom_range(99);
      r.mode = pts_pkg::MODE_TICK;
      r.prio = pts_pkg::PrioW'($urandom_range(63));
      r.ticks = $urandom();
      if (sel < 15) begin
         r.mode = pts_pkg::MODE_START;
         r.prio = pts_pkg::PrioW'($urandom_range(NPRIO));
      end else if (sel < 49) begin
         r.mode = pts_pkg::MODE_DELAY;
         if ($urandom_range(9) == 0) r.ticks = $urandom_range(60, 1);
         else r.ticks = $urandom_range(5, 1);
      end else if (sel < 88) begin
         r.mode = pts_pkg::MODE_TICK;
      end else if (sel < 92) begin
         r.mode = MODE_UNUSED;
      end else if (sel < 95) begin
         r.mode = pts_pkg::MODE_START;
      end else if (sel < 98) begin
         r.mode = pts_pkg::MODE_DELAY;
         r.ticks = '0;
      end else if ($urandom_range(3) == 0) begin
         r.mode = pts_pkg::MODE_DELAY;
      end
      return r;
   endfunction

   task automatic flag_error(string msg);
      if (sched_err_count < MAX_PRINTS) $display("mismatch: %s", msg);
      sched_err_count++;
   endtask

   task automatic wait_drained();
      while (sched_stim_q.size() != 0 || req_valid || sched_expected_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic load_random(int unsigned n);
      repeat (n) sched_stim_q.push_back(mk_random_req());
   endtask

   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) sched_expected_q.push_back(sched_predict(req_data));
         if (!req_valid || req_ready) begin
            if (sched_stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= sched_stim_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_hold_counter
      if (rsp_hold_go) begin
         rsp_hold_left <= RSP_HOLD_CYCLES;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      pts_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sched_expected_q.size() == 0) begin
               flag_error("result transaction with nothing expected");
            end else begin
               want = sched_expected_q.pop_front();
               if (rsp_data.next_prio !== want.next_prio)
                  flag_error($sformatf("next_prio got %0d want %0d",
                                       rsp_data.next_prio, want.next_prio));
               if (rsp_data.switch_needed !== want.switch_needed)
                  flag_error($sformatf("switch_needed got %0d want %0d",
                                       rsp_data.switch_needed, want.switch_needed));
               if (rsp_data.status !== want.status)
                  flag_error($sformatf("status got %0d want %0d",
                                       rsp_data.status, want.status));
            end
         end
         rsp_ready <= (rsp_hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty tick, idle delay, idle thread, limits, zero and longest delay
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_TICK, 0, '0));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_DELAY, 0, 32'd5));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_START, 0, '0));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_START, 0, '0));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_START, NPRIO + 1, '0));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_START, 63, '1));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_START, 1, '0));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_START, NPRIO, '0));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_DELAY, 0, '0));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_DELAY, 0, '1));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_DELAY, 0, 32'd1));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_TICK, 0, '0));
      sched_stim_q.push_back(mk_req(MODE_UNUSED, 63, '1));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_START, 1, '0));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_START, 16, '0));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_DELAY, 0, 32'd2));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_TICK, 0, '0));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_TICK, 0, '0));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_DELAY, 0, 32'd3));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_DELAY, 0, 32'd1));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_TICK, 0, '0));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_TICK, 0, '0));
      sched_stim_q.push_back(mk_req(pts_pkg::MODE_TICK, 0, '0));
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 53; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 53; end
            default: begin send_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         load_random(310);
         wait_drained();
      end

      // long receiver hold-off with the sender pushing all the time
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_go = 1'b1;
      @(negedge clock);
      rsp_hold_go = 1'b0;
      load_random(60);
      wait_drained();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sched_err_count == 0 && sched_expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #3000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
